// File: hdl/dcd_pkg.sv
// Package for the door crossing detector.
// Holds field widths, item and register codes, and the controller interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

  localparam int unsigned MAX_LINKS = 64;
  localparam int unsigned LINK_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned ZONE_W    = 8;
  localparam int unsigned DIST_W    = 40;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned PT_W      = 2 * COORD_W;
  localparam int unsigned HDR_W     = 1 + 2 * ZONE_W;
  localparam int unsigned PT_DEPTH  = 4 * MAX_LINKS;

  localparam logic [CNT_W-1:0]  LINK_COUNT_RST = 7'd0;
  localparam logic [DIST_W-1:0] JUMP_RST       = 40'd65536;
  localparam logic [DIST_W-1:0] MARGIN_RST     = 40'd16384;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR  = 2'd0,
    KIND_PT   = 2'd1,
    KIND_POSE = 2'd2,
    KIND_ZONE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_COUNT = 2'd0,
    CFG_JUMP       = 2'd1,
    CFG_MARGIN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PS_OLD   = 3'd0,
    PS_NEW   = 3'd1,
    PS_P0    = 3'd2,
    PS_P1    = 3'd3,
    PS_POST0 = 3'd4,
    PS_POST1 = 3'd5,
    PS_ORIG  = 3'd6
  } pt_sel_e;

  typedef struct packed {
    logic    cap_item;
    logic    hdr_wr;
    logic    pt_wr;
    logic    zone_set;
    logic    fresh_clr;
    logic    hdr_rd;
    logic    pt_rd;
    logic    pt_slot;
    logic    lat_hdr;
    logic    lat_p0;
    logic    lat_p1;
    logic    mul_en;
    logic    op_cross;
    pt_sel_e sel_a;
    pt_sel_e sel_b;
    pt_sel_e sel_p;
    logic [1:0] dst;
    logic    idx_clr;
    logic    idx_inc;
    logic    arm;
    logic    disarm;
    logic    fire;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  fresh;
    logic  armed;
    logic  jump_ok;
    logic  scan_done;
    logic  hdr_hit;
    logic  cross_hit;
    logic  side_ok;
    logic  fire_ok;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/dcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/dcd_datapath.sv
// Datapath of the door crossing detector: item and state registers, link table RAMs,
// the shared two-multiplier cross product and distance unit, and the result registers.
// Depends on dcd_pkg and dcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module dcd_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [dcd_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [dcd_pkg::LINK_W-1:0]    link_index_i,
  input  wire logic [dcd_pkg::SLOT_W-1:0]    point_slot_i,
  input  wire logic [dcd_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic [dcd_pkg::COORD_W-1:0]   coord_y_i,
  input  wire logic                          is_door_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_a_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_b_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_now_i,
  input  wire logic                          cfg_wr_i,
  input  wire logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dcd_pkg::DIST_W-1:0]    cfg_data_i,
  input  wire dcd_pkg::cmd_t                 cmd_i,
  output dcd_pkg::stat_t                     stat_o,
  output logic                               warp_fired_o,
  output logic [dcd_pkg::LINK_W-1:0]         warp_link_o,
  output logic [dcd_pkg::ZONE_W-1:0]         target_zone_o,
  output logic                               from_side_o,
  output logic                               crossing_armed_o
);

  import dcd_pkg::*;

  function automatic logic [PT_W-1:0] pick(input pt_sel_e s,
      input logic [PT_W-1:0] o, input logic [PT_W-1:0] n,
      input logic [PT_W-1:0] a, input logic [PT_W-1:0] b,
      input logic [PT_W-1:0] c, input logic [PT_W-1:0] d,
      input logic [PT_W-1:0] g);
    logic [PT_W-1:0] r;
    case (s)
      PS_OLD:   r = o;
      PS_NEW:   r = n;
      PS_P0:    r = a;
      PS_P1:    r = b;
      PS_POST0: r = c;
      PS_POST1: r = d;
      PS_ORIG:  r = g;
      default:  r = o;
    endcase
    return r;
  endfunction

  // A difference saturates the squared distance once its magnitude reaches 2^20.
  function automatic logic too_far(input logic signed [DIFF_W-1:0] v);
    logic all0;
    logic all1;
    all0 = (v[DIFF_W-1:20] == '0);
    all1 = (v[DIFF_W-1:20] == '1);
    return !(all0 || (all1 && (v[19:0] != '0)));
  endfunction

  kind_e                kind_q;
  logic [LINK_W-1:0]    idx_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PT_W-1:0]      item_pt_q;
  logic                 door_q;
  logic [ZONE_W-1:0]    za_q, zb_q, znow_q;

  logic [CNT_W-1:0]     link_count_q;
  logic [DIST_W-1:0]    jump_q, margin_q;

  logic [ZONE_W-1:0]    zone_q;
  logic                 fresh_q;
  logic [PT_W-1:0]      last_q;
  logic                 armed_q;
  logic [PT_W-1:0]      orig_q, post0_q, post1_q;
  logic [LINK_W-1:0]    alink_q;
  logic [ZONE_W-1:0]    azone_q;
  logic                 aside_q;
  logic                 fired_q;

  logic [CNT_W-1:0]     i_q;
  logic                 side_q;
  logic [ZONE_W-1:0]    tzone_q;
  logic [PT_W-1:0]      p0_q, p1_q;

  logic [HDR_W-1:0]     hdr_rd;
  logic [PT_W-1:0]      pt_rd;

  logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
  logic                 v1_q, op1_q, sat1_q;
  logic [1:0]           dst1_q;
  logic [3:0]           pos_q, neg_q;
  logic [SUM_W-1:0]     dist_q;
  logic                 dsat_q;

  logic [PT_W-1:0]      pa, pb, pp;
  logic signed [DIFF_W-1:0] dx, dy, ex, ey, m_b, m_d;
  logic signed [SUM_W-1:0]  diff;
  logic [CNT_W-1:0]     n_links;
  logic                 hdr_door;
  logic [ZONE_W-1:0]    hdr_za, hdr_zb;

  dcd_ram #(.WIDTH(HDR_W), .DEPTH(MAX_LINKS)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hdr_wr),
    .waddr_i (idx_q),
    .wdata_i ({door_q, za_q, zb_q}),
    .re_i    (cmd_i.hdr_rd),
    .raddr_i (i_q[LINK_W-1:0]),
    .rdata_o (hdr_rd)
  );

  dcd_ram #(.WIDTH(PT_W), .DEPTH(PT_DEPTH)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pt_wr),
    .waddr_i ({idx_q, slot_q}),
    .wdata_i (item_pt_q),
    .re_i    (cmd_i.pt_rd),
    .raddr_i ({i_q[LINK_W-1:0], side_q, cmd_i.pt_slot}),
    .rdata_o (pt_rd)
  );

  assign {hdr_door, hdr_za, hdr_zb} = hdr_rd;

  always_comb begin
    pa = pick(cmd_i.sel_a, last_q, item_pt_q, p0_q, p1_q, post0_q, post1_q, orig_q);
    pb = pick(cmd_i.sel_b, last_q, item_pt_q, p0_q, p1_q, post0_q, post1_q, orig_q);
    pp = pick(cmd_i.sel_p, last_q, item_pt_q, p0_q, p1_q, post0_q, post1_q, orig_q);
    dx = DIFF_W'(signed'(pb[PT_W-1:COORD_W])) - DIFF_W'(signed'(pa[PT_W-1:COORD_W]));
    dy = DIFF_W'(signed'(pb[COORD_W-1:0])) - DIFF_W'(signed'(pa[COORD_W-1:0]));
    ex = DIFF_W'(signed'(pp[PT_W-1:COORD_W])) - DIFF_W'(signed'(pa[PT_W-1:COORD_W]));
    ey = DIFF_W'(signed'(pp[COORD_W-1:0])) - DIFF_W'(signed'(pa[COORD_W-1:0]));
    m_b = cmd_i.op_cross ? ey : dx;
    m_d = cmd_i.op_cross ? ex : dy;
    diff = SUM_W'(prod_a_q) - SUM_W'(prod_b_q);
    n_links = (link_count_q > CNT_W'(MAX_LINKS)) ? CNT_W'(MAX_LINKS) : link_count_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_a_q <= dx * m_b;
      prod_b_q <= dy * m_d;
      sat1_q   <= too_far(dx) || too_far(dy);
      op1_q    <= cmd_i.op_cross;
      dst1_q   <= cmd_i.dst;
    end
    if (v1_q) begin
      if (op1_q) begin
        pos_q[dst1_q] <= !diff[SUM_W-1] && (diff != '0);
        neg_q[dst1_q] <= diff[SUM_W-1];
      end else begin
        dist_q <= SUM_W'(prod_a_q) + SUM_W'(prod_b_q);
        dsat_q <= sat1_q;
      end
    end
    if (cmd_i.cap_item) begin
      kind_q    <= kind_e'(kind_i);
      idx_q     <= link_index_i;
      slot_q    <= point_slot_i;
      item_pt_q <= {coord_x_i, coord_y_i};
      door_q    <= is_door_i;
      za_q      <= zone_a_i;
      zb_q      <= zone_b_i;
      znow_q    <= zone_now_i;
    end
    if (cmd_i.lat_hdr) begin
      side_q  <= (hdr_za != zone_q);
      tzone_q <= (hdr_za == zone_q) ? hdr_zb : hdr_za;
    end
    if (cmd_i.lat_p0) begin
      p0_q <= pt_rd;
    end
    if (cmd_i.lat_p1) begin
      p1_q <= pt_rd;
    end
    if (cmd_i.out_load) begin
      warp_fired_o     <= fired_q;
      warp_link_o      <= alink_q;
      target_zone_o    <= azone_q;
      from_side_o      <= aside_q;
      crossing_armed_o <= armed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      link_count_q <= LINK_COUNT_RST;
      jump_q       <= JUMP_RST;
      margin_q     <= MARGIN_RST;
      zone_q       <= '0;
      fresh_q      <= 1'b1;
      last_q       <= '0;
      armed_q      <= 1'b0;
      orig_q       <= '0;
      post0_q      <= '0;
      post1_q      <= '0;
      alink_q      <= '0;
      azone_q      <= '0;
      aside_q      <= 1'b0;
      fired_q      <= 1'b0;
      i_q          <= '0;
    end else begin
      v1_q <= cmd_i.mul_en;
      if (cfg_wr_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LINK_COUNT: link_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_JUMP:       jump_q       <= cfg_data_i;
          CFG_MARGIN:     margin_q     <= cfg_data_i;
          default:        ;
        endcase
      end
      if (cmd_i.cap_item) begin
        fired_q <= 1'b0;
      end
      if (cmd_i.zone_set) begin
        zone_q  <= znow_q;
        fresh_q <= 1'b1;
      end
      if (cmd_i.fresh_clr) begin
        fresh_q <= 1'b0;
      end
      if (cmd_i.idx_clr) begin
        i_q <= '0;
      end else if (cmd_i.idx_inc) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.arm) begin
        armed_q <= 1'b1;
        orig_q  <= last_q;
        post0_q <= p0_q;
        post1_q <= p1_q;
        alink_q <= i_q[LINK_W-1:0];
        azone_q <= tzone_q;
        aside_q <= side_q;
      end
      if (cmd_i.disarm) begin
        armed_q <= 1'b0;
      end
      if (cmd_i.fire) begin
        armed_q <= 1'b0;
        fresh_q <= 1'b1;
        fired_q <= 1'b1;
      end
      if (cmd_i.out_load && (kind_q == KIND_POSE)) begin
        last_q <= item_pt_q;
      end
    end
  end

  always_comb begin
    stat_o.kind      = kind_q;
    stat_o.fresh     = fresh_q;
    stat_o.armed     = armed_q;
    stat_o.jump_ok   = !dsat_q && (dist_q < SUM_W'(jump_q));
    stat_o.fire_ok   = dsat_q || (dist_q > SUM_W'(margin_q));
    stat_o.scan_done = (i_q >= n_links);
    stat_o.hdr_hit   = hdr_door && ((hdr_za == zone_q) || (hdr_zb == zone_q));
    stat_o.side_ok   = (pos_q[0] && neg_q[1]) || (neg_q[0] && pos_q[1]);
    stat_o.cross_hit = stat_o.side_ok &&
                       ((pos_q[2] && neg_q[3]) || (neg_q[2] && pos_q[3]));
  end

endmodule

`default_nettype wire

// File: hdl/dcd_ctrl.sv
// Controller of the door crossing detector: one-hot sequencer over item handling,
// the link scan and the armed check, plus the input and output handshakes.
// Depends on dcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire dcd_pkg::stat_t stat_i,
  output dcd_pkg::cmd_t       cmd_o
);

  import dcd_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_DISP = 21'h000002,
    S_DW   = 21'h000004,
    S_DC   = 21'h000008,
    S_A0   = 21'h000010,
    S_A1   = 21'h000020,
    S_A2   = 21'h000040,
    S_AW   = 21'h000080,
    S_AE   = 21'h000100,
    S_SH   = 21'h000200,
    S_SK   = 21'h000400,
    S_SP0  = 21'h000800,
    S_SP1  = 21'h001000,
    S_SP2  = 21'h002000,
    S_C0   = 21'h004000,
    S_C1   = 21'h008000,
    S_C2   = 21'h010000,
    S_C3   = 21'h020000,
    S_CW   = 21'h040000,
    S_CE   = 21'h080000,
    S_FIN  = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel_a = PS_OLD;
    cmd_o.sel_b = PS_NEW;
    cmd_o.sel_p = PS_OLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        case (stat_i.kind)
          KIND_HDR:  cmd_o.hdr_wr = 1'b1;
          KIND_PT:   cmd_o.pt_wr = 1'b1;
          KIND_ZONE: cmd_o.zone_set = 1'b1;
          KIND_POSE: begin
            if (stat_i.fresh) begin
              cmd_o.fresh_clr = 1'b1;
            end else begin
              cmd_o.mul_en = 1'b1;
              state_d = S_DW;
            end
          end
          default: ;
        endcase
      end
      S_DW: state_d = S_DC;
      S_DC: begin
        if (!stat_i.jump_ok) begin
          state_d = S_FIN;
        end else if (stat_i.armed) begin
          state_d = S_A0;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_SH;
        end
      end
      S_A0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_a = PS_POST0;
        cmd_o.sel_b = PS_POST1;
        cmd_o.sel_p = PS_ORIG;
        cmd_o.dst = 2'd0;
        state_d = S_A1;
      end
      S_A1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_a = PS_POST0;
        cmd_o.sel_b = PS_POST1;
        cmd_o.sel_p = PS_NEW;
        cmd_o.dst = 2'd1;
        state_d = S_A2;
      end
      S_A2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.sel_a = PS_ORIG;
        cmd_o.sel_b = PS_NEW;
        state_d = S_AW;
      end
      S_AW: state_d = S_AE;
      S_AE: begin
        if (!stat_i.side_ok) begin
          cmd_o.disarm = 1'b1;
        end else if (stat_i.fire_ok) begin
          cmd_o.fire = 1'b1;
        end
        state_d = S_FIN;
      end
      S_SH: begin
        if (stat_i.scan_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.hdr_rd = 1'b1;
          state_d = S_SK;
        end
      end
      S_SK: begin
        if (stat_i.hdr_hit) begin
          cmd_o.lat_hdr = 1'b1;
          state_d = S_SP0;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_SH;
        end
      end
      S_SP0: begin
        cmd_o.pt_rd = 1'b1;
        state_d = S_SP1;
      end
      S_SP1: begin
        cmd_o.pt_rd = 1'b1;
        cmd_o.pt_slot = 1'b1;
        cmd_o.lat_p0 = 1'b1;
        state_d = S_SP2;
      end
      S_SP2: begin
        cmd_o.lat_p1 = 1'b1;
        state_d = S_C0;
      end
      S_C0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_p = PS_P0;
        cmd_o.dst = 2'd0;
        state_d = S_C1;
      end
      S_C1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_p = PS_P1;
        cmd_o.dst = 2'd1;
        state_d = S_C2;
      end
      S_C2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_a = PS_P0;
        cmd_o.sel_b = PS_P1;
        cmd_o.sel_p = PS_OLD;
        cmd_o.dst = 2'd2;
        state_d = S_C3;
      end
      S_C3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_cross = 1'b1;
        cmd_o.sel_a = PS_P0;
        cmd_o.sel_b = PS_P1;
        cmd_o.sel_p = PS_NEW;
        cmd_o.dst = 2'd3;
        state_d = S_CW;
      end
      S_CW: state_d = S_CE;
      S_CE: begin
        cmd_o.arm = stat_i.cross_hit;
        cmd_o.idx_inc = 1'b1;
        state_d = S_SH;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/door_crossing_detector.sv
// Door crossing detector: tracks poses against a table of door links and reports crossings.
// Top level; joins the controller and the datapath, which holds the link table RAMs.
// Depends on dcd_pkg, dcd_ctrl and dcd_datapath.
//
// Items enter on the in channel and each item gives exactly one result on the out
// channel. Header and point items load the link table, zone items set the current zone,
// and pose items run the crossing logic. The config channel is always ready and writes
// link_count, jump_limit_sq or crossing_margin_sq; write it only while the block is idle.
// One item is processed at a time. Loads, zone items and fresh poses go straight to the
// result. A pose whose jump is too large ends after the distance check, and an armed
// pose runs the side and distance checks. An unarmed pose scans the links up to
// link_count, capped at MAX_LINKS, and runs the cross products for each door link of the
// current zone on the shared two-multiplier unit, one product pair per cycle.
// The result sits in an output register, so the next item is taken while it waits; a
// stalled receiver holds the following item's result back and stops further transfers.
// Reset clears the armed state, current zone and pose and marks the next pose fresh; the
// link table holds no defined contents until it is loaded.
`timescale 1ns / 1ps
`default_nettype none

module door_crossing_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dcd_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [dcd_pkg::LINK_W-1:0]    link_index_i,
  input  wire logic [dcd_pkg::SLOT_W-1:0]    point_slot_i,
  input  wire logic [dcd_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic [dcd_pkg::COORD_W-1:0]   coord_y_i,
  input  wire logic                          is_door_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_a_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_b_i,
  input  wire logic [dcd_pkg::ZONE_W-1:0]    zone_now_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               warp_fired_o,
  output logic [dcd_pkg::LINK_W-1:0]         warp_link_o,
  output logic [dcd_pkg::ZONE_W-1:0]         target_zone_o,
  output logic                               from_side_o,
  output logic                               crossing_armed_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dcd_pkg::DIST_W-1:0]    cfg_data_i
);

  import dcd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  dcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dcd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .link_index_i     (link_index_i),
    .point_slot_i     (point_slot_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .is_door_i        (is_door_i),
    .zone_a_i         (zone_a_i),
    .zone_b_i         (zone_b_i),
    .zone_now_i       (zone_now_i),
    .cfg_wr_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .warp_fired_o     (warp_fired_o),
    .warp_link_o      (warp_link_o),
    .target_zone_o    (target_zone_o),
    .from_side_o      (from_side_o),
    .crossing_armed_o (crossing_armed_o)
  );

  a_fire_disarms : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && warp_fired_o) |-> !crossing_armed_o)
    else $error("warp fired while still armed");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  a_arm_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd.arm |-> (stat.kind == KIND_POSE))
    else $error("arming outside a pose item");

endmodule

`default_nettype wire
